/* design/dual_lfsr_bit_generator_with_stats_unit_assert.svh */
// assertion macros for the keystream generator with statistics
`ifndef DUAL_LFSR_BIT_GENERATOR_WITH_STATS_UNIT_ASSERT_SVH
`define DUAL_LFSR_BIT_GENERATOR_WITH_STATS_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define DLBG_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("dlbg assertion failed");

`define DLBG_ASSERT_NEXT(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("dlbg assertion failed");

`else

`define DLBG_ASSERT(label, prop)

`define DLBG_ASSERT_NEXT(label, cond, conseq)

`endif

`endif

/* design/dlbg_pkg.sv */
// shared types, constants and helpers for the keystream generator with statistics
package dlbg_pkg;

  localparam int MAX_LAG    = 31;
  localparam int COUNT_BITS = 32;
  localparam int NUM_LAGS   = MAX_LAG + 1;
  localparam int LAG_W      = $clog2(NUM_LAGS);

  localparam int NUM_PAT   = 30;
  localparam int PAT1_BASE = 0;
  localparam int PAT2_BASE = 2;
  localparam int PAT3_BASE = 6;
  localparam int PAT4_BASE = 14;

  localparam logic [6:0] IDX_PAT   = 7'd0;
  localparam logic [6:0] IDX_AGREE = 7'd30;
  localparam logic [6:0] IDX_DIS   = 7'd62;
  localparam logic [6:0] IDX_STEP  = 7'd94;

  localparam logic [1:0] FUNC_GEN     = 2'd0;
  localparam logic [1:0] FUNC_READ    = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;

  localparam logic [2:0] CFG_SEED_FIRST = 3'd0;
  localparam logic [2:0] CFG_SEED_W0    = 3'd1;
  localparam logic [2:0] CFG_SEED_W1    = 3'd2;
  localparam logic [2:0] CFG_SEED_W2    = 3'd3;
  localparam logic [2:0] CFG_SEED_W3    = 3'd4;
  localparam logic [2:0] CFG_WARMUP     = 3'd5;

  localparam logic [31:0] SEED_FIRST_RST = 32'h003b2c1d;
  localparam logic [31:0] SEED_W0_RST    = 32'h003b2c1d;
  localparam logic [31:0] SEED_W1_RST    = 32'h7e8f9a0b;
  localparam logic [31:0] SEED_W2_RST    = 32'h5c6d7e8f;
  localparam logic [31:0] SEED_W3_RST    = 32'h1a2b3c4a;
  localparam logic [31:0] WARMUP_RST     = 32'd64;

  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    logic [1:0] func;
    logic [6:0] counter_index;
  } item_t;

  typedef struct packed {
    logic        out_bit;
    logic [31:0] counter_value;
    logic        status;
  } result_t;

  typedef struct packed {
    logic [31:0]      first;
    logic [3:0][31:0] second;
  } seeds_t;

  typedef struct packed {
    logic step;
    logic restart;
    logic warm;
    logic b;
  } cell_ctrl_t;

  function automatic count_t sat_inc(input count_t c);
    count_t r;
    r = (c == '1) ? c : c + count_t'(1);
    return r;
  endfunction

endpackage

/* design/dlbg_keystream.sv */
// two shift registers and the combined keystream bit
module dlbg_keystream import dlbg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  seeds_t     seeds,
  output logic       ks_bit
);

  logic [31:0]      first;
  logic [31:0]      first_next;
  logic [3:0][31:0] second;
  logic [3:0][31:0] second_next;
  logic             fb1;
  logic             fb2;

  always_comb begin
    fb1 = first[0] ^ first[3];
    fb2 = second[0][0] ^ second[0][7] ^ second[0][2];
    first_next = (first >> 1) | {12'b0, fb1, 19'b0};
    for (int k = 0; k < 3; k++) begin
      second_next[k] = {second[k+1][0], second[k][31:1]};
    end
    second_next[3] = (second[3] >> 1) | {9'b0, fb2, 22'b0};
  end

  // low bits after the shift
  assign ks_bit = first[1] ^ second[0][1];

  always_ff @(posedge clk) begin
    if (rst) begin
      first  <= SEED_FIRST_RST;
      second <= {SEED_W3_RST, SEED_W2_RST, SEED_W1_RST, SEED_W0_RST};
    end else if (ctrl.restart) begin
      first  <= seeds.first;
      second <= seeds.second;
    end else if (ctrl.step) begin
      first  <= first_next;
      second <= second_next;
    end
  end

endmodule

/* design/dlbg_pattern_stats.sv */
// counts of one- to four-bit keystream patterns
module dlbg_pattern_stats import dlbg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  output count_t     cnt [NUM_PAT]
);

  logic [3:0] recent_bits;
  logic [1:0] recent_len;
  logic [3:0] rb_new;
  logic [2:0] len;
  logic [4:0] idx1;
  logic [4:0] idx2;
  logic [4:0] idx3;
  logic [4:0] idx4;
  logic [NUM_PAT-1:0] inc;

  always_comb begin
    rb_new = {recent_bits[2:0], ctrl.b};
    len    = {1'b0, recent_len} + 3'd1;
    idx1   = 5'(PAT1_BASE) + {4'b0, ctrl.b};
    idx2   = 5'(PAT2_BASE) + {3'b0, rb_new[1:0]};
    idx3   = 5'(PAT3_BASE) + {2'b0, rb_new[2:0]};
    idx4   = 5'(PAT4_BASE) + {1'b0, rb_new};
    for (int i = 0; i < NUM_PAT; i++) begin
      inc[i] = (5'(i) == idx1)
            || ((len >= 3'd2) && (5'(i) == idx2))
            || ((len >= 3'd3) && (5'(i) == idx3))
            || ((len >= 3'd4) && (5'(i) == idx4));
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      recent_bits <= '0;
      recent_len  <= '0;
      for (int i = 0; i < NUM_PAT; i++) begin
        cnt[i] <= '0;
      end
    end else if (ctrl.step) begin
      if (len >= 3'd4) begin
        recent_bits <= {1'b0, rb_new[2:0]};
        recent_len  <= 2'd3;
      end else begin
        recent_bits <= rb_new;
        recent_len  <= len[1:0];
      end
      for (int i = 0; i < NUM_PAT; i++) begin
        if (inc[i]) begin
          cnt[i] <= sat_inc(cnt[i]);
        end
      end
    end
  end

endmodule

/* design/dlbg_lag_cell.sv */
// one lag of the autocorrelation chain: window bit plus agree and disagree counts
module dlbg_lag_cell import dlbg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic       prev_bit,
  output logic       win_bit,
  output count_t     agree,
  output count_t     disagree
);

  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      win_bit  <= 1'b0;
      agree    <= '0;
      disagree <= '0;
    end else if (ctrl.step) begin
      win_bit <= prev_bit;
      if (ctrl.warm) begin
        if (prev_bit == ctrl.b) begin
          agree <= sat_inc(agree);
        end else begin
          disagree <= sat_inc(disagree);
        end
      end
    end
  end

endmodule

/* design/dual_lfsr_bit_generator_with_stats_unit.sv */
// top level of the keystream generator with pattern and autocorrelation statistics
// a result is registered in the output register, or in the skid entry on a stall
// throughput: one transaction per cycle while the skid entry is empty; a two-entry
// output stage keeps input open while one result is held by a stalled consumer
// reset: synchronous, restores default seeds and warm-up, reloads both shift registers
// and clears all statistics at once (no clearing pass)
module dual_lfsr_bit_generator_with_stats_unit import dlbg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

`include "dual_lfsr_bit_generator_with_stats_unit_assert.svh"

  seeds_t      seeds;
  logic [31:0] warmup;
  logic [31:0] step_count;
  logic        accept;
  logic        ks_bit;
  cell_ctrl_t  ctrl;
  count_t      pat_cnt   [NUM_PAT];
  count_t      agree_cnt [NUM_LAGS];
  count_t      dis_cnt   [NUM_LAGS];
  logic        lag_bit   [NUM_LAGS];
  logic [6:0]  lag_off;
  logic [31:0] rd_val;
  logic        rd_err;
  result_t     res;
  result_t     skid;
  logic        skid_valid;

  assign item_stall = skid_valid;
  assign accept     = item_valid && !item_stall;

  always_comb begin
    ctrl.step    = accept && (item.func == FUNC_GEN);
    ctrl.restart = accept && (item.func == FUNC_RESTART);
    ctrl.warm    = (step_count >= warmup);
    ctrl.b       = ks_bit;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seeds.first  <= SEED_FIRST_RST;
      seeds.second <= {SEED_W3_RST, SEED_W2_RST, SEED_W1_RST, SEED_W0_RST};
      warmup       <= WARMUP_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SEED_FIRST: seeds.first     <= cfg_data;
        CFG_SEED_W0:    seeds.second[0] <= cfg_data;
        CFG_SEED_W1:    seeds.second[1] <= cfg_data;
        CFG_SEED_W2:    seeds.second[2] <= cfg_data;
        CFG_SEED_W3:    seeds.second[3] <= cfg_data;
        CFG_WARMUP:     warmup          <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      step_count <= '0;
    end else if (ctrl.step && (step_count != '1)) begin
      step_count <= step_count + 32'd1;
    end
  end

  dlbg_keystream u_keystream (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .seeds  (seeds),
    .ks_bit (ks_bit)
  );

  dlbg_pattern_stats u_pattern (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .cnt  (pat_cnt)
  );

  // autocorrelation chain, window bits move one cell per step
  for (genvar k = 0; k < NUM_LAGS; k++) begin : g_lag
    if (k == 0) begin : g_head
      dlbg_lag_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .prev_bit (ks_bit),
        .win_bit  (lag_bit[k]),
        .agree    (agree_cnt[k]),
        .disagree (dis_cnt[k])
      );
    end else begin : g_body
      dlbg_lag_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .prev_bit (lag_bit[k-1]),
        .win_bit  (lag_bit[k]),
        .agree    (agree_cnt[k]),
        .disagree (dis_cnt[k])
      );
    end
  end

  // counter read selection
  always_comb begin
    rd_val  = '0;
    rd_err  = 1'b0;
    lag_off = '0;
    if (item.counter_index inside {[IDX_PAT:IDX_AGREE-7'd1]}) begin
      rd_val = 32'(pat_cnt[item.counter_index[4:0]]);
    end else if (item.counter_index inside {[IDX_AGREE:IDX_DIS-7'd1]}) begin
      lag_off = item.counter_index - IDX_AGREE;
      if (lag_off <= 7'(MAX_LAG)) begin
        rd_val = 32'(agree_cnt[lag_off[LAG_W-1:0]]);
      end
    end else if (item.counter_index inside {[IDX_DIS:IDX_STEP-7'd1]}) begin
      lag_off = item.counter_index - IDX_DIS;
      if (lag_off <= 7'(MAX_LAG)) begin
        rd_val = 32'(dis_cnt[lag_off[LAG_W-1:0]]);
      end
    end else if (item.counter_index == IDX_STEP) begin
      rd_val = step_count;
    end else begin
      rd_err = 1'b1;
    end
  end

  always_comb begin
    res = '0;
    case (item.func)
      FUNC_GEN: begin
        res.out_bit = ks_bit;
      end
      FUNC_READ: begin
        res.counter_value = rd_val;
        res.status        = rd_err;
      end
      default: ;
    endcase
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || !result_stall) begin
      if (skid_valid) begin
        result <= skid;
      end else if (accept) begin
        result <= res;
      end
    end else if (accept) begin
      skid <= res;
    end
  end

  `DLBG_ASSERT(a_skid_behind_result, !skid_valid || result_valid)
  `DLBG_ASSERT_NEXT(a_skid_fill, result_valid && result_stall && accept, skid_valid)
  `DLBG_ASSERT_NEXT(a_restart_clears, ctrl.restart, step_count == '0)
  `DLBG_ASSERT_NEXT(a_step_counts, ctrl.step && (step_count != '1), step_count == $past(step_count) + 32'd1)

endmodule
